// ===== hdl/lpsm_pkg.sv =====
// Shared types and constants for the line position unit.
// Command/status structs between controller and datapath, field widths, register codes.
// No dependencies.
`default_nettype none

package lpsm_pkg;

    localparam int SENS_W           = 10;
    localparam int POS_W            = 13;
    localparam int MARK_W           = 3;
    localparam int POS_STEP         = 1000;
    localparam int SENSOR_PORTS     = 8;
    localparam int SENSOR_COUNT_DEF = 8;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR = 1'b1;
    localparam logic [SENS_W-1:0] LINE_THR_RST  = SENS_W'(300);
    localparam logic [SENS_W-1:0] NOISE_THR_RST = SENS_W'(50);

    // Side-mark codes
    localparam logic [MARK_W-1:0] MARK_NONE    = 3'd0;
    localparam logic [MARK_W-1:0] MARK_RIGHT   = 3'd1;
    localparam logic [MARK_W-1:0] MARK_LEFT    = 3'd2;
    localparam logic [MARK_W-1:0] MARK_BOTH    = 3'd3;
    localparam logic [MARK_W-1:0] MARK_UNKNOWN = 3'd4;

    typedef struct packed {
        logic load;      // capture a new request
        logic scan;      // run detection step at idx
        logic acc;       // centroid accumulation step at idx
        logic div_init;  // seed the divider
        logic div_step;  // one quotient bit
        logic emit;      // load output registers, update stored position after a divide
    } dp_cmd_t;

    typedef struct packed {
        logic no_run;
        logic no_weight;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/lpsm_dp.sv =====
// Datapath: config registers, sensor capture, run scan, weighted sums, divider, output regs.
// Driven step by step by lpsm_ctrl; depends on lpsm_pkg.
`default_nettype none

module lpsm_dp #(
    parameter int SENSOR_COUNT = lpsm_pkg::SENSOR_COUNT_DEF
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    input  wire logic                                            cfg_wr_en,
    input  wire logic [lpsm_pkg::CFG_IDX_W-1:0]                  cfg_addr,
    input  wire logic [lpsm_pkg::SENS_W-1:0]                     cfg_wdata,
    input  wire logic [SENSOR_COUNT-1:0][lpsm_pkg::SENS_W-1:0]   sensors,
    input  wire lpsm_pkg::dp_cmd_t                               cmd,
    input  wire logic [$clog2(SENSOR_COUNT)-1:0]                 idx,
    output lpsm_pkg::dp_status_t                                 status,
    output logic [lpsm_pkg::POS_W-1:0]                           line_position,
    output logic [lpsm_pkg::MARK_W-1:0]                          mark_code
);
    import lpsm_pkg::*;

    localparam int IDX_W   = $clog2(SENSOR_COUNT);
    localparam int RUN_W   = $clog2((SENSOR_COUNT + 1) / 2 + 1);
    localparam int SENS_MAX = (1 << SENS_W) - 1;
    localparam int DEN_W   = $clog2(SENSOR_COUNT * SENS_MAX + 1);
    localparam int NUM_W   =
        $clog2(SENS_MAX * POS_STEP * (SENSOR_COUNT * (SENSOR_COUNT - 1) / 2) + 1);
    localparam int DIST_W  = POS_W + 1;
    localparam int SPAN    = (SENSOR_COUNT - 1) * POS_STEP;
    localparam int HALF    = SPAN / 2;
    localparam int TERM_W  = SENS_W + POS_W;

    logic [SENS_W-1:0]       line_thr_reg, noise_thr_reg;
    logic [SENS_W-1:0]       val_reg [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] above_reg;
    logic [POS_W-1:0]        last_reg;

    logic [IDX_W-1:0]        cur_start_reg, best_s_reg, best_e_reg;
    logic [RUN_W-1:0]        runs_reg, best_ord_reg;
    logic [DIST_W-1:0]       best_d_reg;

    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [POS_W-1:0]        quo_reg;

    logic [POS_W-1:0]        line_position_reg;
    logic [MARK_W-1:0]       mark_code_reg;

    // Scan step
    logic [SENSOR_COUNT-1:0] prev_mask, next_mask;
    logic                    run_start, run_end;
    logic [IDX_W-1:0]        run_s;
    logic [IDX_W:0]          sum_se;
    logic [DIST_W-1:0]       two_last, mid, run_dist;
    logic                    take_run;

    // Accumulate step
    logic [SENS_W-1:0]       cur_val;
    logic                    in_best, drop, keep;
    logic [SENS_W-1:0]       weight;
    logic [POS_W-1:0]        idx_pos;
    logic [TERM_W-1:0]       term;

    // Divider step
    logic [DEN_W:0]          trial;
    logic                    ge;

    // Output selection
    logic [POS_W-1:0]        pos_out;
    logic [MARK_W-1:0]       mark_out;
    logic                    upd_last;

    assign prev_mask = {above_reg[SENSOR_COUNT-2:0], 1'b0};
    assign next_mask = {1'b0, above_reg[SENSOR_COUNT-1:1]};

    always_comb begin
        run_start = above_reg[idx] & ~prev_mask[idx];
        run_end   = above_reg[idx] & ~next_mask[idx];
        run_s     = run_start ? idx : cur_start_reg;
        sum_se    = {1'b0, run_s} + {1'b0, idx};
        two_last  = {last_reg, 1'b0};
        mid       = DIST_W'(sum_se) * DIST_W'(POS_STEP);
        run_dist  = (two_last > mid) ? (two_last - mid) : (mid - two_last);
        // first run always taken, later ones only when strictly nearer
        take_run  = (runs_reg == '0) || (run_dist < best_d_reg);
    end

    always_comb begin
        cur_val = val_reg[idx];
        in_best = (idx >= best_s_reg) && (idx <= best_e_reg);
        drop    = above_reg[idx] && (runs_reg > RUN_W'(1)) && !in_best;
        keep    = (cur_val > noise_thr_reg) && !drop;
        weight  = keep ? cur_val : '0;
        idx_pos = POS_W'(idx) * POS_W'(POS_STEP);
        term    = TERM_W'(weight) * TERM_W'(idx_pos);
    end

    always_comb begin
        trial = {rem_reg, quo_reg[POS_W-1]};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_comb begin
        upd_last = 1'b0;
        if (status.no_run) begin
            pos_out = (last_reg < POS_W'(HALF)) ? '0 : POS_W'(SPAN);
        end else if (status.no_weight) begin
            pos_out = last_reg;
        end else begin
            pos_out  = quo_reg;
            upd_last = 1'b1;
        end

        if (status.no_run || runs_reg <= RUN_W'(1)) begin
            mark_out = MARK_NONE;
        end else if (best_ord_reg == '0) begin
            mark_out = MARK_RIGHT;
        end else if (best_ord_reg == RUN_W'(1) && runs_reg == RUN_W'(2)) begin
            mark_out = MARK_LEFT;
        end else if (best_ord_reg == RUN_W'(1) && runs_reg == RUN_W'(3)) begin
            mark_out = MARK_BOTH;
        end else begin
            mark_out = MARK_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_thr_reg  <= LINE_THR_RST;
            noise_thr_reg <= NOISE_THR_RST;
            last_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_LINE_THR:  line_thr_reg  <= cfg_wdata;
                    CFG_NOISE_THR: noise_thr_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.emit && upd_last) begin
                last_reg <= pos_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                val_reg[k]   <= sensors[k];
                above_reg[k] <= (sensors[k] > line_thr_reg);
            end
            runs_reg <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
        end
        if (cmd.scan) begin
            if (run_start) begin
                cur_start_reg <= idx;
            end
            if (run_end) begin
                runs_reg <= runs_reg + RUN_W'(1);
                if (take_run) begin
                    best_s_reg   <= run_s;
                    best_e_reg   <= idx;
                    best_d_reg   <= run_dist;
                    best_ord_reg <= runs_reg;
                end
            end
        end
        if (cmd.acc) begin
            num_reg <= num_reg + NUM_W'(term);
            den_reg <= den_reg + DEN_W'(weight);
        end
        // quotient fits in POS_W bits, so the upper numerator bits start below den
        if (cmd.div_init) begin
            rem_reg <= DEN_W'(num_reg >> POS_W);
            quo_reg <= num_reg[POS_W-1:0];
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[POS_W-2:0], ge};
        end
        if (cmd.emit) begin
            line_position_reg <= pos_out;
            mark_code_reg     <= mark_out;
        end
    end

    assign status.no_run    = ~|above_reg;
    assign status.no_weight = (den_reg == '0);
    assign line_position    = line_position_reg;
    assign mark_code        = mark_code_reg;

endmodule

`default_nettype wire

// ===== hdl/lpsm_ctrl.sv =====
// Controller: sequences scan, accumulate and divide phases and owns the handshakes.
// Issues dp_cmd_t to lpsm_dp; depends on lpsm_pkg.
`default_nettype none

module lpsm_ctrl #(
    parameter int SENSOR_COUNT = lpsm_pkg::SENSOR_COUNT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    input  wire lpsm_pkg::dp_status_t             status,
    output lpsm_pkg::dp_cmd_t                     cmd,
    output logic [$clog2(SENSOR_COUNT)-1:0]       idx
);
    import lpsm_pkg::*;

    localparam int IDX_W = $clog2(SENSOR_COUNT);
    localparam int STEPS = (SENSOR_COUNT > POS_W) ? SENSOR_COUNT : POS_W;
    localparam int CNT_W = $clog2(STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACCUM,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free, last_sensor, last_bit;

    assign out_free    = !m_valid_reg || m_ready;
    assign last_sensor = (cnt_reg == CNT_W'(SENSOR_COUNT - 1));
    assign last_bit    = (cnt_reg == CNT_W'(POS_W - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                cnt_next = '0;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_sensor) begin
                    cnt_next   = '0;
                    state_next = status.no_run ? ST_DONE : ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.acc  = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_sensor) begin
                    cnt_next   = '0;
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                // nothing weighted: skip the divide, stored position is repeated
                state_next   = status.no_weight ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (last_bit) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.emit = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = cmd.emit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign idx     = cnt_reg[IDX_W-1:0];

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.scan, cmd.acc, cmd.div_init, cmd.div_step, cmd.emit}))
        else $error("more than one datapath command at once");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("output overwritten while stalled");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("result lost after emit");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("accepted request did not start scan");

endmodule

`default_nettype wire

// ===== hdl/line_position_with_side_marks_unit.sv =====
// Line position unit with side-mark detection.
// Input channel s_*: one request of eight 10-bit reflectance readings (sensor_0 leftmost);
// only the first SENSOR_COUNT readings are used.
// Output channel m_*: line_position (index * 1000, weighted centroid) and mark_code.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata write line_threshold (0) and noise_threshold (1);
// write only while no request is in flight.
// Sequence: a request runs a run scan over the SENSOR_COUNT sensors, a weighted accumulation
// over them, a divider seed step and a 13-bit restoring divide; then the result is loaded
// into the output register. A new request is taken only in idle, once the last result has
// been loaded. With no sensor on the line the result follows straight after the scan; with
// nothing above the noise threshold the divide is skipped.
// Reset: thresholds return to 300 and 50, stored position to 0, no result pending.
// Stall: the result waits in the output register; the block finishes the next request
// and holds it until the register frees, with s_ready low meanwhile.
// Depends on lpsm_pkg, lpsm_ctrl, lpsm_dp.
`default_nettype none

module line_position_with_side_marks_unit #(
    parameter int SENSOR_COUNT = lpsm_pkg::SENSOR_COUNT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [lpsm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      s_sensor_0,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      s_sensor_1,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      s_sensor_2,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      s_sensor_3,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      s_sensor_4,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      s_sensor_5,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      s_sensor_6,
    input  wire logic [lpsm_pkg::SENS_W-1:0]      s_sensor_7,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [lpsm_pkg::POS_W-1:0]            m_line_position,
    output logic [lpsm_pkg::MARK_W-1:0]           m_mark_code
);
    import lpsm_pkg::*;

    logic [SENSOR_PORTS-1:0][SENS_W-1:0]  sens_all;
    dp_cmd_t                              cmd;
    dp_status_t                           status;
    logic [$clog2(SENSOR_COUNT)-1:0]      idx;

    assign sens_all = {s_sensor_7, s_sensor_6, s_sensor_5, s_sensor_4,
                       s_sensor_3, s_sensor_2, s_sensor_1, s_sensor_0};

    lpsm_ctrl #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd),
        .idx     (idx)
    );

    lpsm_dp #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .sensors       (sens_all[SENSOR_COUNT-1:0]),
        .cmd           (cmd),
        .idx           (idx),
        .status        (status),
        .line_position (m_line_position),
        .mark_code     (m_mark_code)
    );

endmodule

`default_nettype wire
